// File: design/oets_pkg.sv
`default_nettype none

package oets_pkg;

   // Sequencer states: collect a set, sort it in place, stream it out
   typedef enum logic [1:0] {
      ST_LOAD = 2'd0,
      ST_SORT = 2'd1,
      ST_EMIT = 2'd2
   } oets_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // write the accepted beat into the next free cell
      logic sort;   // run one compare-exchange pass
      logic odd;    // pass selects odd-index pairs
      logic emit;   // move cell 0 into the output register, shift down
   } oets_cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic swap;       // current pass exchanges at least one pair
      logic count_one;  // exactly one element left in the store
   } oets_sts_type;

endpackage

`default_nettype wire

// File: design/oets_datapath.sv
`default_nettype none

module oets_datapath
   import oets_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16,
   parameter int DATA_WIDTH   = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire oets_cmd_type                 cmd,
   output oets_sts_type                      sts,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   output logic signed [DATA_WIDTH-1:0]      rsp_sorted_value,
   output logic                              rsp_last_res,
   output logic                              rsp_overflow
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   logic [DATA_WIDTH-1:0] store_ff [MAX_ELEMENTS];
   logic [DATA_WIDTH-1:0] store_in [MAX_ELEMENTS];
   logic [DATA_WIDTH-1:0] right_val [MAX_ELEMENTS];
   logic [DATA_WIDTH-1:0] left_val  [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] take_right;
   logic [MAX_ELEMENTS-1:0] take_left;
   logic [MAX_ELEMENTS-2:0] swp;

   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic          full;

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic                         last_ff, last_in;
   logic                         ovf_ff, ovf_in;

   assign full = (count_ff == CW'(MAX_ELEMENTS));

   // One comparator per pair; a pass enables the pairs of its parity
   // that lie fully inside the filled part of the store.
   for (genvar p = 0; p < MAX_ELEMENTS - 1; p++) begin : g_pair
      localparam logic PAR = 1'(p % 2);
      assign swp[p] = cmd.sort && (cmd.odd == PAR)
                   && (CW'(p + 1) < count_ff)
                   && ($signed(store_ff[p]) > $signed(store_ff[p + 1]));
   end

   // Neighbor wiring per cell
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      if (i < MAX_ELEMENTS - 1) begin : g_r
         assign right_val[i]  = store_ff[i + 1];
         assign take_right[i] = swp[i];
      end else begin : g_rn
         assign right_val[i]  = store_ff[i];
         assign take_right[i] = 1'b0;
      end
      if (i > 0) begin : g_l
         assign left_val[i]  = store_ff[i - 1];
         assign take_left[i] = swp[i - 1];
      end else begin : g_ln
         assign left_val[i]  = store_ff[i];
         assign take_left[i] = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         store_in[i] = store_ff[i];
         if (cmd.load) begin
            if (count_ff == CW'(i)) begin
               store_in[i] = req_value;
            end
         end else if (cmd.emit) begin
            store_in[i] = right_val[i];
         end else if (take_right[i]) begin
            store_in[i] = right_val[i];
         end else if (take_left[i]) begin
            store_in[i] = left_val[i];
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      ovf_in      = ovf_ff;
      if (cmd.load) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (cmd.emit) begin
         value_in = store_ff[0];
         last_in  = sts.count_one;
         ovf_in   = overflow_ff;
         count_in = count_ff - CW'(1);
         if (sts.count_one) begin
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      ovf_ff   <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign sts.swap      = |swp;
   assign sts.count_one = (count_ff == CW'(1));

   assign rsp_sorted_value = value_ff;
   assign rsp_last_res     = last_ff;
   assign rsp_overflow     = ovf_ff;

endmodule

`default_nettype wire

// File: design/oets_ctrl.sv
`default_nettype none

module oets_ctrl
   import oets_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_last,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output oets_cmd_type      cmd,
   input  wire oets_sts_type sts
);

   oets_state_type state_ff, state_in;
   logic           phase_ff, phase_in;
   logic           idle_ff, idle_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_fire;
   logic           out_free;

   assign req_fire = req_valid && (state_ff == ST_LOAD);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_last) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (!sts.swap && idle_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && sts.count_one) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs and sequencing registers
   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      phase_in     = phase_ff;
      idle_in      = idle_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_fire;
            phase_in  = 1'b0;
            idle_in   = 1'b0;
         end
         ST_SORT: begin
            cmd.sort = 1'b1;
            cmd.odd  = phase_ff;
            phase_in = !phase_ff;
            idle_in  = !sts.swap;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         phase_ff     <= 1'b0;
         idle_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sort, cmd.emit}))
      else $error("controller issued more than one datapath command");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("emit overwrote a beat still waiting at the output");

   a_final_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.count_one) |=> (state_ff == ST_LOAD && rsp_valid_ff))
      else $error("final element did not return the sequencer to load");

   a_sort_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT && $past(state_ff) == ST_LOAD) |-> (!phase_ff && !idle_ff))
      else $error("sort did not start with an even pass");
`endif

endmodule

`default_nettype wire

// File: design/odd_even_transposition_sorter.sv
`default_nettype none

// Load: one beat per cycle, last beat starts the sort.
// Sort: one compare-exchange pass per cycle over all pairs of its parity in
//   parallel; it runs until two passes in a row swap nothing.
// Emit: one beat per cycle from the output register while the output is not
//   stalled. The next set loads while the final beat waits.
// Reset (synchronous, active high) empties the set and clears the output valid.
module odd_even_transposition_sorter
   import oets_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16,
   parameter int DATA_WIDTH   = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   input  wire logic                         req_last,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_sorted_value,
   output logic                              rsp_last_res,
   output logic                              rsp_overflow
);

   oets_cmd_type cmd;
   oets_sts_type sts;

   // Sequencer: load / sort / emit, pass parity and idle-pass tracking,
   // output valid handshake.
   oets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Row of element cells with a comparator between each neighbor pair.
   // Elements beyond capacity are dropped and flagged on every beat of the set.
   // Emission shifts the row toward cell 0, so no cell is read by address.
   oets_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_value        (req_value),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_res     (rsp_last_res),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire
